// ===== rtl/kts_pkg.sv =====
// Package for the keyframe timeline sequencer: codes, field widths, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package kts_pkg;

  localparam int TIME_W  = 31;
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 18;
  localparam int DELTA_W = 24;
  localparam int SPEED_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 18;
  localparam int DCNT_W     = 5;

  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_KEY_WR  = 2'd1;
  localparam logic [1:0] MODE_EVT_WR  = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_EVENT  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEATING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED    = 3'd4;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL   = 10'b00_0000_0010,
    S_UPD   = 10'b00_0000_0100,
    S_KSCAN = 10'b00_0000_1000,
    S_KDIV  = 10'b00_0001_0000,
    S_KEMIT = 10'b00_0010_0000,
    S_ESCAN = 10'b00_0100_0000,
    S_EDIV  = 10'b00_1000_0000,
    S_EEMIT = 10'b01_0000_0000,
    S_STAT  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic idle;
    logic capture;
    logic mul;
    logic upd;
    logic idx_inc;
    logic idx_clr;
    logic div_load_key;
    logic div_load_evt;
    logic div_step;
    logic emit_key;
    logic emit_evt;
    logic emit_stat;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic tick_live_in;
    logic paused;
    logic key_scan_end;
    logic evt_scan_end;
    logic key_hit;
    logic evt_hit;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/kts_in_if.sv =====
// Input item channel of the keyframe timeline sequencer.
// Depends on kts_pkg.
interface kts_in_if import kts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [2:0]           slot;
  logic [DELTA_W-1:0]   delta;
  logic [TIME_W-1:0]    start_time;
  logic [TIME_W-1:0]    end_time;
  logic                 slot_enable;

  modport source (output valid, mode, slot, delta, start_time, end_time, slot_enable,
                  input ready);
  modport sink (input valid, mode, slot, delta, start_time, end_time, slot_enable,
                output ready);
endinterface

// ===== rtl/kts_out_if.sv =====
// Result item channel of the keyframe timeline sequencer.
// Depends on kts_pkg.
interface kts_out_if import kts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [2:0]               which_slot;
  logic [FRAC_W-1:0]        fraction;
  logic signed [POS_W-1:0]  position;
  logic                     finished;
  logic                     restarted;
  logic                     running;
  logic                     last;

  modport source (output valid, kind, which_slot, fraction, position, finished, restarted,
                  running, last, input ready);
  modport sink (input valid, kind, which_slot, fraction, position, finished, restarted,
                running, last, output ready);
endinterface

// ===== rtl/kts_cfg_if.sv =====
// Configuration write channel of the keyframe timeline sequencer.
// Depends on kts_pkg.
interface kts_cfg_if import kts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/kts_ctrl.sv =====
// Sequencer FSM: steps one item through update, keyframe scan, event scan
// and status. Depends on kts_pkg; drives the datapath through cmd_t.
module kts_ctrl import kts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          cmd.capture = 1'b1;
          if (sts.tick_live_in) begin
            state_nxt = sts.paused ? S_KSCAN : S_MUL;
          end else begin
            state_nxt = S_STAT;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_KSCAN;
      end
      S_KSCAN: begin
        if (sts.key_scan_end) begin
          // event scan starts again from slot 0
          cmd.idx_clr = 1'b1;
          state_nxt   = S_ESCAN;
        end else if (sts.key_hit) begin
          cmd.div_load_key = 1'b1;
          state_nxt        = S_KDIV;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_KDIV: begin
        if (sts.div_done) begin
          state_nxt = S_KEMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_KEMIT: begin
        if (sts.out_free) begin
          cmd.emit_key = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_KSCAN;
        end
      end
      S_ESCAN: begin
        if (sts.evt_scan_end) begin
          state_nxt = S_STAT;
        end else if (sts.evt_hit) begin
          cmd.div_load_evt = 1'b1;
          state_nxt        = S_EDIV;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EDIV: begin
        if (sts.div_done) begin
          state_nxt = S_EEMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EEMIT: begin
        if (sts.out_free) begin
          cmd.emit_evt = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_ESCAN;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.emit_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/kts_dp.sv =====
// Datapath: config registers, slot tables, progress update, serial
// fraction divider and the output register. Depends on kts_pkg and the channel interfaces.
module kts_dp import kts_pkg::*; #(
  parameter int KEYFRAME_SLOTS = 8,
  parameter int EVENT_SLOTS    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  kts_in_if.sink        in_if,
  kts_out_if.source     out_if,
  kts_cfg_if.sink       cfg_if,
  input  cmd_t          cmd,
  output sts_t          sts
);

  localparam int MAX_SLOTS = (KEYFRAME_SLOTS > EVENT_SLOTS) ? KEYFRAME_SLOTS : EVENT_SLOTS;
  localparam int IDX_W     = $clog2(MAX_SLOTS + 1);
  localparam int KIX_W     = (KEYFRAME_SLOTS > 1) ? $clog2(KEYFRAME_SLOTS) : 1;
  localparam int EIX_W     = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

  // configuration
  logic [TIME_W-1:0]  duration_r;
  logic               repeating_r;
  logic               reverse_r;
  logic [SPEED_W-1:0] speed_r;
  logic               paused_r;

  // timeline state
  logic signed [POS_W-1:0] progress_r;
  logic                    active_r;
  logic                    tick_live_r;
  logic                    restart_r;
  logic [DELTA_W-1:0]      delta_r;
  logic [POS_W-1:0]        mult_r;
  logic [IDX_W-1:0]        idx_r;

  logic [TIME_W-1:0]         key_start_r [KEYFRAME_SLOTS];
  logic [TIME_W-1:0]         key_end_r   [KEYFRAME_SLOTS];
  logic [KEYFRAME_SLOTS-1:0] key_valid_r;
  logic [TIME_W-1:0]         evt_time_r  [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0]    evt_valid_r;
  logic [EVENT_SLOTS-1:0]    evt_played_r;

  // divider
  logic [TIME_W-1:0]  rem_r;
  logic [TIME_W-1:0]  den_r;
  logic [FRAC_W-1:0]  sh_r;
  logic [FRAC_W-1:0]  q_r;
  logic [DCNT_W-1:0]  dcnt_r;

  // output register
  logic                    out_valid_r;
  logic [1:0]              kind_r;
  logic [2:0]              which_r;
  logic [FRAC_W-1:0]       frac_r;
  logic signed [POS_W-1:0] pos_r;
  logic                    fin_r;
  logic                    rst_flag_r;
  logic                    run_r;
  logic                    last_r;

  logic                    key_scan_end, evt_scan_end;
  logic [TIME_W-1:0]       ks, ke, et;
  logic                    key_hit, evt_hit;
  logic signed [POS_W+1:0] pext, mext, sum;
  logic signed [POS_W-1:0] upd_val;
  logic [POS_W-1:0]        div_num;
  logic [TIME_W-1:0]       div_den;
  logic [POS_W-1:0]        r2;
  logic                    fin_now;
  logic                    out_free;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = cmd.idle;

  assign key_scan_end = (32'(idx_r) >= KEYFRAME_SLOTS);
  assign evt_scan_end = (32'(idx_r) >= EVENT_SLOTS);
  assign ks = key_start_r[idx_r[KIX_W-1:0]];
  assign ke = key_end_r[idx_r[KIX_W-1:0]];
  assign et = evt_time_r[idx_r[EIX_W-1:0]];

  assign key_hit = !key_scan_end && key_valid_r[idx_r[KIX_W-1:0]]
                   && (progress_r > $signed({1'b0, ks}))
                   && (progress_r < $signed({1'b0, ke}));
  assign evt_hit = !evt_scan_end && evt_valid_r[idx_r[EIX_W-1:0]]
                   && !evt_played_r[idx_r[EIX_W-1:0]]
                   && ($signed({1'b0, et}) <= progress_r);

  always_comb begin
    pext = {{2{progress_r[POS_W-1]}}, progress_r};
    mext = $signed({2'b00, mult_r});
    sum  = reverse_r ? (pext - mext) : (pext + mext);
    if (sum[POS_W+1:POS_W-1] == 3'b000 || sum[POS_W+1:POS_W-1] == 3'b111) begin
      upd_val = sum[POS_W-1:0];
    end else begin
      upd_val = sum[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (cmd.div_load_key) begin
      div_num = POS_W'(progress_r - $signed({1'b0, ks}));
      div_den = ke - ks;
    end else begin
      div_num = progress_r;
      div_den = duration_r;
    end
  end

  assign r2       = {rem_r, sh_r[FRAC_W-1]};
  assign fin_now  = tick_live_r && (progress_r > $signed({1'b0, duration_r}));
  assign out_free = !out_valid_r || out_if.ready;

  assign sts.in_valid     = in_if.valid;
  assign sts.tick_live_in = (in_if.mode == MODE_TICK) && active_r;
  assign sts.paused       = paused_r;
  assign sts.key_scan_end = key_scan_end;
  assign sts.evt_scan_end = evt_scan_end;
  assign sts.key_hit      = key_hit;
  assign sts.evt_hit      = evt_hit;
  assign sts.div_done     = (dcnt_r == '0);
  assign sts.out_free     = out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r  <= TIME_W'(65536);
      repeating_r <= 1'b0;
      reverse_r   <= 1'b0;
      speed_r     <= SPEED_W'(1);
      paused_r    <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_DURATION:  duration_r  <= cfg_if.data[TIME_W-1:0];
        CFG_REPEATING: repeating_r <= cfg_if.data[0];
        CFG_REVERSE:   reverse_r   <= cfg_if.data[0];
        CFG_SPEED:     speed_r     <= cfg_if.data[SPEED_W-1:0];
        CFG_PAUSED:    paused_r    <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r   <= '0;
      active_r     <= 1'b0;
      tick_live_r  <= 1'b0;
      restart_r    <= 1'b0;
      idx_r        <= '0;
      dcnt_r       <= '0;
      key_valid_r  <= '0;
      evt_valid_r  <= '0;
      evt_played_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.capture) begin
        idx_r       <= '0;
        tick_live_r <= (in_if.mode == MODE_TICK) && active_r;
        restart_r   <= (in_if.mode == MODE_RESTART);
        case (in_if.mode)
          MODE_KEY_WR: begin
            for (int i = 0; i < KEYFRAME_SLOTS; i++) begin
              if (32'(in_if.slot) == i) key_valid_r[i] <= in_if.slot_enable;
            end
          end
          MODE_EVT_WR: begin
            for (int i = 0; i < EVENT_SLOTS; i++) begin
              if (32'(in_if.slot) == i) begin
                evt_valid_r[i]  <= in_if.slot_enable;
                evt_played_r[i] <= 1'b0;
              end
            end
          end
          MODE_RESTART: begin
            progress_r   <= '0;
            evt_played_r <= '0;
            active_r     <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.upd) progress_r <= upd_val;
      if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.idx_clr) begin
        idx_r <= '0;
      end
      if (cmd.div_load_key || cmd.div_load_evt) begin
        if (div_num == '0 || div_num >= {div_den, 2'b00}) begin
          dcnt_r <= '0;
        end else begin
          dcnt_r <= DCNT_W'(DIV_STEPS);
        end
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 1'b1;
      end
      if (cmd.emit_evt) evt_played_r[idx_r[EIX_W-1:0]] <= 1'b1;
      if (cmd.emit_key || cmd.emit_evt || cmd.emit_stat) out_valid_r <= 1'b1;
      if (cmd.emit_stat && fin_now) begin
        if (repeating_r) begin
          progress_r   <= '0;
          evt_played_r <= '0;
          active_r     <= 1'b1;
        end else begin
          active_r <= 1'b0;
        end
      end
    end
  end

  // payload: slot tables, product, divider, result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      delta_r <= in_if.delta;
      if (in_if.mode == MODE_KEY_WR) begin
        for (int i = 0; i < KEYFRAME_SLOTS; i++) begin
          if (32'(in_if.slot) == i) begin
            key_start_r[i] <= in_if.start_time;
            key_end_r[i]   <= in_if.end_time;
          end
        end
      end
      if (in_if.mode == MODE_EVT_WR) begin
        for (int i = 0; i < EVENT_SLOTS; i++) begin
          if (32'(in_if.slot) == i) evt_time_r[i] <= in_if.start_time;
        end
      end
    end
    if (cmd.mul) mult_r <= delta_r * speed_r;

    if (cmd.div_load_key || cmd.div_load_evt) begin
      den_r <= div_den;
      rem_r <= TIME_W'(div_num >> 2);
      sh_r  <= {div_num[1:0], {(FRAC_W-2){1'b0}}};
      if (div_num == '0) begin
        q_r <= '0;
      end else if (div_num >= {div_den, 2'b00}) begin
        q_r <= FRAC_MAX;
      end else begin
        q_r <= '0;
      end
    end else if (cmd.div_step) begin
      sh_r <= {sh_r[FRAC_W-2:0], 1'b0};
      if (r2 >= {1'b0, den_r}) begin
        rem_r <= TIME_W'(r2 - {1'b0, den_r});
        q_r   <= {q_r[FRAC_W-2:0], 1'b1};
      end else begin
        rem_r <= r2[TIME_W-1:0];
        q_r   <= {q_r[FRAC_W-2:0], 1'b0};
      end
    end

    if (cmd.emit_key || cmd.emit_evt) begin
      kind_r     <= cmd.emit_key ? KIND_KEY : KIND_EVENT;
      which_r    <= 3'(idx_r);
      frac_r     <= q_r;
      pos_r      <= progress_r;
      fin_r      <= 1'b0;
      rst_flag_r <= 1'b0;
      run_r      <= active_r;
      last_r     <= 1'b0;
    end else if (cmd.emit_stat) begin
      kind_r     <= KIND_STATUS;
      which_r    <= '0;
      frac_r     <= '0;
      fin_r      <= fin_now;
      last_r     <= 1'b1;
      if (fin_now && repeating_r) begin
        pos_r      <= '0;
        rst_flag_r <= 1'b1;
        run_r      <= 1'b1;
      end else begin
        pos_r      <= progress_r;
        rst_flag_r <= restart_r;
        run_r      <= active_r && !fin_now;
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.kind       = kind_r;
  assign out_if.which_slot = which_r;
  assign out_if.fraction   = frac_r;
  assign out_if.position   = pos_r;
  assign out_if.finished   = fin_r;
  assign out_if.restarted  = rst_flag_r;
  assign out_if.running    = run_r;
  assign out_if.last       = last_r;

endmodule

// ===== rtl/keyframe_timeline_sequencer_unit.sv =====
// Flow: slot writes, restarts and stopped ticks go from accept straight to the status
// state and its output register. A running tick first passes the multiply and update
// states (skipped while paused), then scans each slot; each reported slot is loaded into
// the divider, takes up to 18 divide steps and a done check, then waits for a free output.
// One item in flight; input is taken again once the status item is registered.
// Reset: config returns to defaults, progress 0, timeline stopped, all slot flags cleared.
module keyframe_timeline_sequencer_unit import kts_pkg::*; #(
  parameter int KEYFRAME_SLOTS = 8,
  parameter int EVENT_SLOTS    = 8
) (
  input logic        clk,
  input logic        rst_n,
  kts_in_if.sink     in_if,
  kts_out_if.source  out_if,
  kts_cfg_if.sink    cfg_if
);

  cmd_t cmd;
  sts_t sts;

  kts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  kts_dp #(
    .KEYFRAME_SLOTS (KEYFRAME_SLOTS),
    .EVENT_SLOTS    (EVENT_SLOTS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

// ===== tb/kts_tb_pkg.sv =====
// Item and result types for the keyframe timeline sequencer testbench.
// Depends on kts_pkg.
package kts_tb_pkg;
  import kts_pkg::*;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         slot;
    logic [DELTA_W-1:0] delta;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic               slot_enable;
  } timeline_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              which_slot;
    logic [FRAC_W-1:0]       fraction;
    logic signed [POS_W-1:0] position;
    logic                    finished;
    logic                    restarted;
    logic                    running;
    logic                    last;
  } timeline_result_t;

endpackage

// ===== tb/tb_top.sv =====
// Testbench for keyframe_timeline_sequencer_unit: random and directed timeline items,
// results checked against a behavioral predictor. Depends on kts_pkg, kts_tb_pkg, RTL.
module tb_top;
  import kts_pkg::*;
  import kts_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  kts_in_if  in_if();
  kts_out_if out_if();
  kts_cfg_if cfg_if();

  keyframe_timeline_sequencer_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  // predictor copy of configuration and state
  logic [30:0] duration_q;
  logic        repeating_q, reverse_q, paused_q;
  logic [7:0]  speed_q;
  logic signed [63:0] progress_q;
  logic        active_q;
  logic [30:0] k_start [NSLOT];
  logic [30:0] k_end [NSLOT];
  logic        k_valid [NSLOT];
  logic [30:0] ev_time [NSLOT];
  logic        ev_valid [NSLOT];
  logic        ev_played [NSLOT];

  timeline_item_t   pending_items[$];
  timeline_result_t expected_results[$];
  int errors = 0;
  int accepted = 0;
  int queued = 0;
  bit hold_long = 0;

  function automatic logic [FRAC_W-1:0] norm_frac(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return (num == 0) ? '0 : FRAC_MAX;
    q = (num << 16) / den;
    return (q > 64'(FRAC_MAX)) ? FRAC_MAX : q[FRAC_W-1:0];
  endfunction

  function automatic timeline_result_t make_res(logic [1:0] kind, int which,
      logic [FRAC_W-1:0] f, logic fin, logic rs, logic lst);
    timeline_result_t r;
    r.kind = kind;
    r.which_slot = which[2:0];
    r.fraction = f;
    r.position = progress_q[31:0];
    r.finished = fin;
    r.restarted = rs;
    r.running = active_q;
    r.last = lst;
    return r;
  endfunction

  task automatic restart_timeline();
    progress_q = 0;
    for (int i = 0; i < NSLOT; i++) ev_played[i] = 1'b0;
    active_q = 1'b1;
  endtask

  task automatic predict_timeline(timeline_item_t it);
    logic fin, rs;
    logic signed [63:0] d;
    fin = 0;
    rs = 0;
    case (it.mode)
      MODE_KEY_WR: begin
        k_start[it.slot] = it.start_time;
        k_end[it.slot] = it.end_time;
        k_valid[it.slot] = it.slot_enable;
      end
      MODE_EVT_WR: begin
        ev_time[it.slot] = it.start_time;
        ev_valid[it.slot] = it.slot_enable;
        ev_played[it.slot] = 1'b0;
      end
      MODE_RESTART: begin
        restart_timeline();
        rs = 1;
      end
      default: if (active_q) begin
        if (!paused_q) begin
          d = $signed({40'd0, it.delta}) * $signed({56'd0, speed_q});
          progress_q = reverse_q ? progress_q - d : progress_q + d;
          if (progress_q > 64'sh7FFF_FFFF) progress_q = 64'sh7FFF_FFFF;
          if (progress_q < -64'sh8000_0000) progress_q = -64'sh8000_0000;
        end
        for (int i = 0; i < NSLOT; i++)
          if (k_valid[i] && progress_q > $signed({33'd0, k_start[i]}) &&
              progress_q < $signed({33'd0, k_end[i]}))
            expected_results = {expected_results, make_res(KIND_KEY, i,
              norm_frac(progress_q - k_start[i], {33'd0, k_end[i]} - k_start[i]), 0, 0, 0)};
        for (int i = 0; i < NSLOT; i++)
          if (ev_valid[i] && !ev_played[i] && $signed({33'd0, ev_time[i]}) <= progress_q)
          begin
            ev_played[i] = 1'b1;
            expected_results = {expected_results, make_res(KIND_EVENT, i,
              norm_frac(progress_q, {33'd0, duration_q}), 0, 0, 0)};
          end
        if (progress_q > $signed({33'd0, duration_q})) begin
          fin = 1;
          if (repeating_q) begin
            restart_timeline();
            rs = 1;
          end else begin
            active_q = 1'b0;
          end
        end
      end
    endcase
    expected_results = {expected_results, make_res(KIND_STATUS, 0, '0, fin, rs, 1'b1)};
  endtask

  // driver: bursts and gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_timeline(pending_items.pop_front());
        accepted++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > accepted - (queued - pending_items.size())
                     && pending_items.size() > 0) begin
          in_if.valid <= 1'b1;
          {in_if.mode, in_if.slot, in_if.delta, in_if.start_time, in_if.end_time,
           in_if.slot_enable} <= pending_items[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls; one long hold-off counted here
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_long && hold_cnt == 0) begin
      hold_cnt = 600;
      hold_long = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 9) < 7);
    end
  end

  // monitor
  always @(posedge clk) begin
    timeline_result_t got, exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.kind, out_if.which_slot, out_if.fraction, out_if.position,
             out_if.finished, out_if.restarted, out_if.running, out_if.last};
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %h", $realtime, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch exp kind=%0d slot=%0d frac=%h pos=%h fin=%b rs=%b",
            $realtime, exp_r.kind, exp_r.which_slot, exp_r.fraction, exp_r.position,
            exp_r.finished, exp_r.restarted, " run=%b last=%b", exp_r.running, exp_r.last);
          $display("%0t:          got kind=%0d slot=%0d frac=%h pos=%h fin=%b rs=%b",
            $realtime, got.kind, got.which_slot, got.fraction, got.position,
            got.finished, got.restarted, " run=%b last=%b", got.running, got.last);
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_DURATION:  duration_q = val[30:0];
      CFG_REPEATING: repeating_q = val[0];
      CFG_REVERSE:   reverse_q = val[0];
      CFG_SPEED:     speed_q = val[7:0];
      CFG_PAUSED:    paused_q = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_item(logic [1:0] m, logic [2:0] s, logic [23:0] d, logic [30:0] st,
                          logic [30:0] en, logic ena);
    timeline_item_t it;
    it = '{m, s, d, st, en, ena};
    pending_items = {pending_items, it};
    queued++;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // small times so windows and events get hit often
  function automatic logic [30:0] rnd_time(logic [30:0] span);
    return ($urandom_range(0, 15) == 0) ? 31'($urandom) : 31'($urandom_range(0, span));
  endfunction

  task automatic random_phase(int count, logic [30:0] span);
    int kind;
    logic [30:0] a, b;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 19);
      a = rnd_time(span);
      b = rnd_time(span);
      if (kind < 3)
        add_item(MODE_KEY_WR, 3'($urandom), 24'($urandom), a,
                 ($urandom_range(0, 5) == 0) ? a - 1 : a + b, $urandom_range(0, 4) != 0);
      else if (kind < 6)
        add_item(MODE_EVT_WR, 3'($urandom), 24'($urandom), a, 31'($urandom),
                 $urandom_range(0, 3) != 0);
      else if (kind < 7)
        add_item(MODE_RESTART, 3'($urandom), 24'($urandom), a, b, 1'($urandom));
      else add_item(MODE_TICK, 3'($urandom), ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                    24'($urandom_range(0, span / 16 + 1)), a, b, 1'($urandom));
    end
  endtask

  initial begin
    in_if.valid = 0; in_if.mode = 0; in_if.slot = 0; in_if.delta = 0;
    in_if.start_time = 0; in_if.end_time = 0; in_if.slot_enable = 0;
    out_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = 0; cfg_if.data = 0;
    duration_q = 31'd65536; repeating_q = 0; reverse_q = 0; speed_q = 8'd1; paused_q = 0;
    progress_q = 0; active_q = 0;
    for (int i = 0; i < NSLOT; i++) begin
      k_start[i] = 0; k_end[i] = 0; k_valid[i] = 0;
      ev_time[i] = 0; ev_valid[i] = 0; ev_played[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stopped tick, slot writes, restart, keys/events, overflow, pause
    add_item(MODE_TICK, 0, 24'hFFFFFF, 0, 0, 0);
    add_item(MODE_KEY_WR, 0, 0, 31'd0, 31'd65536, 1);
    add_item(MODE_KEY_WR, 7, 24'hFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1);
    add_item(MODE_KEY_WR, 3, 0, 31'd1000, 31'd40000, 1);
    add_item(MODE_EVT_WR, 0, 0, 31'd0, 0, 1);
    add_item(MODE_EVT_WR, 7, 0, 31'd30000, 0, 1);
    add_item(MODE_EVT_WR, 5, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
    add_item(MODE_RESTART, 7, 0, 0, 0, 1);
    add_item(MODE_TICK, 0, 24'd0, 0, 0, 0);
    add_item(MODE_TICK, 0, 24'd20000, 0, 0, 0);
    add_item(MODE_TICK, 0, 24'd20000, 0, 0, 0);
    add_item(MODE_TICK, 0, 24'd40000, 0, 0, 0);
    add_item(MODE_TICK, 0, 24'd1, 0, 0, 0);
    add_item(MODE_RESTART, 0, 0, 0, 0, 0);
    drain();
    cfg_write(CFG_SPEED, 32'd255);
    cfg_write(CFG_DURATION, 32'h7FFFFFFF);
    for (int i = 0; i < 10; i++) add_item(MODE_TICK, 0, 24'hFFFFFF, 0, 0, 0);
    drain();
    cfg_write(CFG_REVERSE, 1);
    cfg_write(CFG_PAUSED, 1);
    add_item(MODE_TICK, 0, 24'hFFFFFF, 0, 0, 0);
    drain();
    cfg_write(CFG_PAUSED, 0);
    add_item(MODE_RESTART, 0, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++) add_item(MODE_TICK, 0, 24'hFFFFFF, 0, 0, 0);
    drain();

    // random phases with differing settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_DURATION, 65536); cfg_write(CFG_REVERSE, 0);
             cfg_write(CFG_SPEED, 1); cfg_write(CFG_REPEATING, 1); end
        1: begin cfg_write(CFG_DURATION, 0); cfg_write(CFG_REPEATING, 0); end
        2: begin cfg_write(CFG_DURATION, 200000); cfg_write(CFG_SPEED, 0); end
        3: begin cfg_write(CFG_SPEED, 3); cfg_write(CFG_PAUSED, 1); end
        4: begin cfg_write(CFG_PAUSED, 0); cfg_write(CFG_REVERSE, 1);
             cfg_write(CFG_REPEATING, 1); end
        5: begin cfg_write(CFG_REVERSE, 0); cfg_write(CFG_SPEED, $urandom);
             cfg_write(CFG_DURATION, $urandom); end
        default: begin cfg_write(CFG_SPEED, 2); cfg_write(CFG_DURATION, 131072);
             cfg_write(CFG_REPEATING, $urandom); end
      endcase
      add_item(MODE_RESTART, 0, 0, 0, 0, 0);
      if (ph == 3) hold_long = 1;
      random_phase(32, (ph == 5) ? 31'h7FFFFFFF : 31'd150000);
      while (pending_items.size() > 20) @(posedge clk);
      hold_long = 0;
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kts_pkg.sv
rtl/kts_in_if.sv
rtl/kts_out_if.sv
rtl/kts_cfg_if.sv
rtl/kts_ctrl.sv
rtl/kts_dp.sv
rtl/keyframe_timeline_sequencer_unit.sv
tb/kts_tb_pkg.sv
tb/tb_top.sv
